// File: src/gpa_pkg.sv
// Shared types, constants and helper functions for the GF(2) polynomial ALU.
`default_nettype none

package gpa_pkg;

  localparam int WORD_BITS = 64;
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int DS_W      = 2 * WORD_BITS - 1;
  localparam int DEG_W     = 6;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_CLMUL   = 3'd0,
    CMD_MUL_CYC = 3'd1,
    CMD_MUL_MOD = 3'd2,
    CMD_QUOT    = 3'd3,
    CMD_REM     = 3'd4,
    CMD_EXP     = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LAUNCH,
    ST_MUL,
    ST_DIV,
    ST_EXP_CHK,
    ST_EXP_MR,
    ST_EXP_SQ,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t test;
    word_t red;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t product;
  } mul_rsp_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
    word_t top;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

  // One-hot of the highest set bit, zero for a zero word. A log-depth
  // prefix OR smears the top bit downward, then the edge is isolated.
  function automatic word_t top_onehot(input word_t v);
    word_t s;
    s = v;
    for (int k = 0; k < IDX_W; k++) begin
      s = s | (s >> (1 << k));
    end
    return s & ~(s >> 1);
  endfunction

endpackage

`default_nettype wire

// File: src/gpa_mul_unit.sv
// Shift-and-xor multiplier with conditional reduction, one multiplier bit per cycle.
`default_nettype none

module gpa_mul_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gpa_pkg::mul_req_t req,
  output gpa_pkg::mul_rsp_t     rsp
);

  logic          busy_r, busy_nxt;
  gpa_pkg::word_t a_r, a_nxt;
  gpa_pkg::word_t b_r, b_nxt;
  gpa_pkg::word_t acc_r, acc_nxt;
  gpa_pkg::word_t test_r, test_nxt;
  gpa_pkg::word_t red_r, red_nxt;
  gpa_pkg::word_t a_sh;

  // The multiplier is consumed from the bottom; once it is zero no further
  // step can change the accumulator, so the unit stops early.
  always_comb begin
    a_sh     = {a_r[gpa_pkg::WORD_BITS-2:0], 1'b0};
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    test_nxt = test_r;
    red_nxt  = red_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      test_nxt = req.test;
      red_nxt  = req.red;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_nxt = acc_r ^ a_r;
        end
        a_nxt = ((a_sh & test_r) != '0) ? (a_sh ^ red_r) : a_sh;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    test_r <= test_nxt;
    red_r  <= red_nxt;
  end

  assign rsp.done    = busy_r && (b_r == '0);
  assign rsp.product = acc_r;

endmodule

`default_nettype wire

// File: src/gpa_div_unit.sv
// Long divider over GF(2), one quotient bit per cycle from the top position down.
`default_nettype none

module gpa_div_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gpa_pkg::div_req_t req,
  output gpa_pkg::div_rsp_t     rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [gpa_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  gpa_pkg::word_t                 x_r, x_nxt;
  gpa_pkg::word_t                 q_r, q_nxt;
  logic [gpa_pkg::DS_W-1:0]       ds_r, ds_nxt;
  logic [gpa_pkg::DS_W-1:0]       tb_r, tb_nxt;
  logic                           hit;

  // The divisor and its top bit start shifted up by WORD_BITS-1 in a double
  // width register; bits that land above the word never match the dividend.
  always_comb begin
    hit      = (x_r & tb_r[gpa_pkg::WORD_BITS-1:0]) != '0;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    q_nxt    = q_r;
    ds_nxt   = ds_r;
    tb_nxt   = tb_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = gpa_pkg::IDX_W'(gpa_pkg::WORD_BITS - 1);
      x_nxt    = req.dividend;
      q_nxt    = '0;
      ds_nxt   = {req.divisor, {(gpa_pkg::WORD_BITS-1){1'b0}}};
      tb_nxt   = {req.top, {(gpa_pkg::WORD_BITS-1){1'b0}}};
    end else if (busy_r) begin
      if (hit) begin
        x_nxt = x_r ^ ds_r[gpa_pkg::WORD_BITS-1:0];
      end
      q_nxt  = {q_r[gpa_pkg::WORD_BITS-2:0], hit};
      ds_nxt = ds_r >> 1;
      tb_nxt = tb_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    q_r   <= q_nxt;
    ds_r  <= ds_nxt;
    tb_r  <= tb_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = x_r;

endmodule

`default_nettype wire

// File: src/gf2_polynomial_alu_top.sv
// Top level of the GF(2) polynomial ALU: handshakes, sequencer and result register.
// Multiplies run the multiply unit until operand_b is used up; quotient and remainder
// run the divider (a zero divisor or an unused command skips the units).
// Exponentiation runs one multiply unit pass per set exponent bit plus one squaring per
// exponent bit below the highest set bit. One transaction is in flight at a time; the
// multiply unit works by shift and xor, the divider yields one quotient bit per cycle.
// rst_n is synchronous and active low; it sets ring_degree to 63 and empties the block.
`default_nettype none

module gf2_polynomial_alu_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [2:0]                            in_cmd,
  input  wire logic [gpa_pkg::WORD_BITS-1:0]         in_operand_a,
  input  wire logic [gpa_pkg::WORD_BITS-1:0]         in_operand_b,
  input  wire logic [gpa_pkg::WORD_BITS-1:0]         in_modulus,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [gpa_pkg::WORD_BITS-1:0]              out_result,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [gpa_pkg::DEG_W-1:0]             cfg_wr_data
);

  gpa_pkg::state_t            state_r, state_nxt;
  logic [gpa_pkg::DEG_W-1:0]  ring_degree_r;

  // Operands captured when a transaction is accepted.
  logic [2:0]      cmd_r;
  gpa_pkg::word_t  opa_r, opb_r, mod_r;
  gpa_pkg::word_t  top_r, top_nxt;

  // Exponentiation working registers: running result, base and exponent.
  gpa_pkg::word_t  r_r, r_nxt;
  gpa_pkg::word_t  base_r, base_nxt;
  gpa_pkg::word_t  e_r, e_nxt;

  gpa_pkg::word_t  res_r, res_nxt;
  logic            out_valid_r;
  gpa_pkg::word_t  out_result_r;

  gpa_pkg::mul_req_t mul_req;
  gpa_pkg::mul_rsp_t mul_rsp;
  gpa_pkg::div_req_t div_req;
  gpa_pkg::div_rsp_t div_rsp;

  gpa_pkg::word_t  cyc_test, cyc_red;
  logic            is_div, is_mul, div_by_zero, out_free, e_last;

  assign cyc_test    = gpa_pkg::word_t'(1) << ring_degree_r;
  assign cyc_red     = cyc_test ^ gpa_pkg::word_t'(1);
  assign is_div      = (cmd_r == gpa_pkg::CMD_QUOT) || (cmd_r == gpa_pkg::CMD_REM);
  assign is_mul      = (cmd_r == gpa_pkg::CMD_CLMUL) || (cmd_r == gpa_pkg::CMD_MUL_CYC) ||
                       (cmd_r == gpa_pkg::CMD_MUL_MOD);
  assign div_by_zero = (opb_r == '0);
  assign out_free    = !out_valid_r || out_ready;
  // True when the exponent has no set bit above the one being handled now.
  assign e_last      = (e_r >> 1) == '0;

  gpa_mul_unit u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  gpa_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state. A transaction passes a preparation state, which finds the top bit of the
  // modulus or divisor, then a launch state that starts the multiply or divide unit where needed.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = gpa_pkg::ST_PREP;
        end
      end
      gpa_pkg::ST_PREP: begin
        state_nxt = gpa_pkg::ST_LAUNCH;
      end
      gpa_pkg::ST_LAUNCH: begin
        if (is_mul) begin
          state_nxt = gpa_pkg::ST_MUL;
        end else if (is_div) begin
          state_nxt = div_by_zero ? gpa_pkg::ST_FIN : gpa_pkg::ST_DIV;
        end else if (cmd_r == gpa_pkg::CMD_EXP) begin
          state_nxt = gpa_pkg::ST_EXP_CHK;
        end else begin
          state_nxt = gpa_pkg::ST_FIN;
        end
      end
      gpa_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          state_nxt = gpa_pkg::ST_FIN;
        end
      end
      gpa_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = gpa_pkg::ST_FIN;
        end
      end
      gpa_pkg::ST_EXP_CHK: begin
        if (e_r == '0) begin
          state_nxt = gpa_pkg::ST_FIN;
        end else if (e_r[0]) begin
          state_nxt = gpa_pkg::ST_EXP_MR;
        end else begin
          state_nxt = gpa_pkg::ST_EXP_SQ;
        end
      end
      gpa_pkg::ST_EXP_MR: begin
        if (mul_rsp.done) begin
          state_nxt = e_last ? gpa_pkg::ST_FIN : gpa_pkg::ST_EXP_SQ;
        end
      end
      gpa_pkg::ST_EXP_SQ: begin
        if (mul_rsp.done) begin
          state_nxt = gpa_pkg::ST_EXP_CHK;
        end
      end
      gpa_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = gpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gpa_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: the input handshake and the start requests of both units.
  always_comb begin
    in_ready         = 1'b0;
    mul_req          = '0;
    div_req          = '0;
    div_req.dividend = opa_r;
    div_req.divisor  = opb_r;
    div_req.top      = top_r;
    case (state_r)
      gpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      gpa_pkg::ST_LAUNCH: begin
        mul_req.a = opa_r;
        mul_req.b = opb_r;
        case (cmd_r)
          gpa_pkg::CMD_CLMUL: begin
            mul_req.start = 1'b1;
          end
          gpa_pkg::CMD_MUL_CYC: begin
            mul_req.start = 1'b1;
            mul_req.test  = cyc_test;
            mul_req.red   = cyc_red;
          end
          gpa_pkg::CMD_MUL_MOD: begin
            mul_req.start = 1'b1;
            mul_req.test  = top_r;
            mul_req.red   = mod_r;
          end
          gpa_pkg::CMD_QUOT, gpa_pkg::CMD_REM: begin
            div_req.start = !div_by_zero;
          end
          default: begin
            mul_req.start = 1'b0;
          end
        endcase
      end
      gpa_pkg::ST_EXP_CHK: begin
        // Multiply the running result by the base when the exponent bit is set,
        // otherwise go straight to squaring the base.
        mul_req.start = (e_r != '0);
        mul_req.a     = e_r[0] ? r_r : base_r;
        mul_req.b     = base_r;
        mul_req.test  = cyc_test;
        mul_req.red   = cyc_red;
      end
      gpa_pkg::ST_EXP_MR: begin
        // The final squaring is skipped when no exponent bit remains.
        mul_req.start = mul_rsp.done && !e_last;
        mul_req.a     = base_r;
        mul_req.b     = base_r;
        mul_req.test  = cyc_test;
        mul_req.red   = cyc_red;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Working registers of the sequencer.
  always_comb begin
    top_nxt  = top_r;
    r_nxt    = r_r;
    base_nxt = base_r;
    e_nxt    = e_r;
    res_nxt  = res_r;
    case (state_r)
      gpa_pkg::ST_PREP: begin
        top_nxt = gpa_pkg::top_onehot(is_div ? opb_r : mod_r);
      end
      gpa_pkg::ST_LAUNCH: begin
        res_nxt  = '0;
        r_nxt    = gpa_pkg::word_t'(1);
        base_nxt = opa_r;
        e_nxt    = opb_r;
      end
      gpa_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          res_nxt = mul_rsp.product;
        end
      end
      gpa_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          res_nxt = (cmd_r == gpa_pkg::CMD_REM) ? div_rsp.remainder : div_rsp.quotient;
        end
      end
      gpa_pkg::ST_EXP_CHK: begin
        res_nxt = r_r;
      end
      gpa_pkg::ST_EXP_MR: begin
        if (mul_rsp.done) begin
          r_nxt   = mul_rsp.product;
          res_nxt = mul_rsp.product;
        end
      end
      gpa_pkg::ST_EXP_SQ: begin
        if (mul_rsp.done) begin
          base_nxt = mul_rsp.product;
          e_nxt    = e_r >> 1;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gpa_pkg::ST_IDLE;
      ring_degree_r <= gpa_pkg::DEG_W'(63);
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        ring_degree_r <= cfg_wr_data;
      end
      if ((state_r == gpa_pkg::ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      opa_r <= in_operand_a;
      opb_r <= in_operand_b;
      mod_r <= in_modulus;
    end
    if ((state_r == gpa_pkg::ST_FIN) && out_free) begin
      out_result_r <= res_r;
    end
    top_r  <= top_nxt;
    r_r    <= r_nxt;
    base_r <= base_nxt;
    e_r    <= e_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire
